>>> sv/cbf_pkg.sv
// Shared types for the cubic Bezier flattener: the command and status bundles
// that join the controller and the datapath. No dependencies.
package cbf_pkg;

    // Number of control points that follow an anchor before a segment can complete.
    localparam logic [1:0] CTRL_PTS = 2'd2;

    typedef struct packed {
        logic load_anchor;  // point becomes the anchor of a new curve
        logic load_ctrl;    // point is a pending control point
        logic ctrl_sel;     // 0: first control point, 1: second
        logic load_end;     // point closes a segment; derive its coefficients
        logic setup;        // turn coefficients into forward differences
        logic issue;        // push the current sample into the divide pipeline
        logic emit;         // the issued sample produces a line
        logic last;         // the issued sample is the final one of the segment
    } cbf_cmd_t;

    typedef struct packed {
        logic adv;          // the sample pipeline moves this cycle
    } cbf_status_t;

endpackage

>>> sv/cbf_ctrl.sv
// Controller of the cubic Bezier flattener: tracks curve and segment progress
// and sequences the datapath. Depends on cbf_pkg.
module cbf_ctrl import cbf_pkg::*; #(
    parameter int SAMPLE_STEPS = 60
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        new_curve,
    input  cbf_status_t status,
    output cbf_cmd_t    cmd
);

    localparam int CNT_W = $clog2(SAMPLE_STEPS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } state_t;

    state_t           state_reg, state_next;
    logic             curve_started_reg, curve_started_next;
    logic [1:0]       held_reg, held_next;
    logic             have_prev_reg, have_prev_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             final_sample;

    assign s_tready     = (state_reg == ST_IDLE);
    assign final_sample = (cnt_reg == CNT_W'(SAMPLE_STEPS));

    always_comb begin
        state_next         = state_reg;
        curve_started_next = curve_started_reg;
        held_next          = held_reg;
        have_prev_next     = have_prev_reg;
        cnt_next           = cnt_reg;
        cmd                = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (new_curve || !curve_started_reg) begin
                        // A new anchor drops pending control points and breaks the chain.
                        cmd.load_anchor    = 1'b1;
                        held_next          = '0;
                        have_prev_next     = 1'b0;
                        curve_started_next = 1'b1;
                    end else if (held_reg != CTRL_PTS) begin
                        cmd.load_ctrl = 1'b1;
                        cmd.ctrl_sel  = held_reg[0];
                        held_next     = held_reg + 2'd1;
                    end else begin
                        cmd.load_end = 1'b1;
                        held_next    = '0;
                        state_next   = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                cnt_next   = '0;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (status.adv) begin
                    // Without a previous sample, the first sample only seeds the chain.
                    cmd.issue      = 1'b1;
                    cmd.emit       = have_prev_reg;
                    cmd.last       = final_sample;
                    have_prev_next = 1'b1;
                    cnt_next       = cnt_reg + CNT_W'(1);
                    if (final_sample) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            curve_started_reg <= 1'b0;
            held_reg          <= '0;
            have_prev_reg     <= 1'b0;
            cnt_reg           <= '0;
        end else begin
            state_reg         <= state_next;
            curve_started_reg <= curve_started_next;
            held_reg          <= held_next;
            have_prev_reg     <= have_prev_next;
            cnt_reg           <= cnt_next;
        end
    end

endmodule

>>> sv/cbf_datapath.sv
// Datapath of the cubic Bezier flattener: point storage, forward-difference
// evaluation, exact rounding division pipeline and the output register. Depends on cbf_pkg.
module cbf_datapath import cbf_pkg::*; #(
    parameter int COORD_BITS   = 12,
    parameter int SAMPLE_STEPS = 60
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cbf_cmd_t              cmd,
    output cbf_status_t           status,
    input  logic [COORD_BITS-1:0] point_x,
    input  logic [COORD_BITS-1:0] point_y,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [COORD_BITS-1:0] from_x,
    output logic [COORD_BITS-1:0] from_y,
    output logic [COORD_BITS-1:0] to_x,
    output logic [COORD_BITS-1:0] to_y,
    output logic                  last
);

    localparam int CB     = COORD_BITS;
    localparam int N      = SAMPLE_STEPS;
    localparam longint unsigned DEN = longint'(N) * N * N;
    localparam longint unsigned D2  = 2 * DEN;
    localparam int D2_W   = $clog2(D2 + 1);
    // 2*num + DEN stays below 2^CB * D2.
    localparam int N2_W   = CB + D2_W;
    localparam int ACC_W  = N2_W + 4;
    localparam int M_W    = CB + 2;
    localparam int PROD_W = N2_W + M_W;
    localparam longint unsigned RECIP = (64'd1 << N2_W) / D2;

    localparam logic [M_W-1:0]          RECIP_C = M_W'(RECIP);
    localparam logic [N2_W-1:0]         DEN_C   = N2_W'(DEN);
    localparam logic [N2_W-1:0]         D2_C    = N2_W'(D2);
    localparam logic signed [ACC_W-1:0] K_THREE = ACC_W'(3);
    localparam logic signed [ACC_W-1:0] K_SIX   = ACC_W'(6);
    localparam logic signed [ACC_W-1:0] K_N     = ACC_W'(N);
    localparam logic signed [ACC_W-1:0] K_2N    = ACC_W'(2 * N);
    localparam logic signed [ACC_W-1:0] K_NN    = ACC_W'(N * N);
    localparam logic signed [ACC_W-1:0] K_DEN   = ACC_W'(DEN);

    logic [CB-1:0] pin [2];

    logic [CB-1:0] p0_reg [2];
    logic [CB-1:0] p1_reg [2];
    logic [CB-1:0] p2_reg [2];

    logic signed [ACC_W-1:0] c1_reg [2];
    logic signed [ACC_W-1:0] c2_reg [2];
    logic signed [ACC_W-1:0] c3_reg [2];
    logic signed [ACC_W-1:0] f_reg  [2];
    logic signed [ACC_W-1:0] d1_reg [2];
    logic signed [ACC_W-1:0] d2_reg [2];
    logic signed [ACC_W-1:0] d3_reg [2];

    logic signed [ACC_W-1:0] c1_next [2];
    logic signed [ACC_W-1:0] c2_next [2];
    logic signed [ACC_W-1:0] c3_next [2];
    logic signed [ACC_W-1:0] f0_next [2];
    logic signed [ACC_W-1:0] d1_next [2];
    logic signed [ACC_W-1:0] d2_next [2];
    logic signed [ACC_W-1:0] d3_next [2];

    logic [N2_W-1:0]   n2_next   [2];
    logic [PROD_W-1:0] prod_next [2];
    logic [CB-1:0]     qa_next   [2];
    logic [N2_W-1:0]   qd_next   [2];
    logic [N2_W-1:0]   rem       [2];
    logic [CB-1:0]     q         [2];

    logic              s1_valid_reg, s2_valid_reg;
    logic              s1_emit_reg, s1_last_reg, s2_emit_reg, s2_last_reg;
    logic [N2_W-1:0]   s1_n2_reg   [2];
    logic [PROD_W-1:0] s1_prod_reg [2];
    logic [N2_W-1:0]   s2_n2_reg   [2];
    logic [CB-1:0]     s2_qa_reg   [2];
    logic [N2_W-1:0]   s2_qd_reg   [2];

    logic [CB-1:0] prev_reg [2];
    logic [CB-1:0] from_reg [2];
    logic [CB-1:0] to_reg   [2];
    logic          m_tvalid_reg;
    logic          last_reg;
    logic          adv;

    assign pin[0] = point_x;
    assign pin[1] = point_y;

    // The whole sample pipeline stalls while a line waits in the output register.
    assign adv        = !m_tvalid_reg || m_tready;
    assign status.adv = adv;

    always_comb begin
        logic signed [ACC_W-1:0] pa, pb, pc, pd;
        for (int a = 0; a < 2; a++) begin
            pa = $signed({{(ACC_W - CB){1'b0}}, p0_reg[a]});
            pb = $signed({{(ACC_W - CB){1'b0}}, p1_reg[a]});
            pc = $signed({{(ACC_W - CB){1'b0}}, p2_reg[a]});
            pd = $signed({{(ACC_W - CB){1'b0}}, pin[a]});
            // Power-basis coefficients of the cubic, scaled so that t = i / N.
            c1_next[a] = K_THREE * (pb - pa);
            c2_next[a] = K_THREE * (pa - pb - pb + pc);
            c3_next[a] = pd - K_THREE * pc + K_THREE * pb - pa;
            f0_next[a] = K_DEN * pa;
            // Forward differences at i = 0 of N^3*P0 + N^2*c1*i + N*c2*i^2 + c3*i^3.
            d1_next[a] = K_NN * c1_reg[a] + K_N * c2_reg[a] + c3_reg[a];
            d2_next[a] = K_2N * c2_reg[a] + K_SIX * c3_reg[a];
            d3_next[a] = K_SIX * c3_reg[a];
            // Rounding half up: floor((2*num + DEN) / (2*DEN)).
            n2_next[a]   = {f_reg[a][N2_W-2:0], 1'b0} + DEN_C;
            prod_next[a] = PROD_W'(n2_next[a]) * PROD_W'(RECIP_C);
            // The reciprocal estimate is exact or one too small.
            qa_next[a]   = s1_prod_reg[a][N2_W +: CB];
            qd_next[a]   = N2_W'(qa_next[a]) * D2_C;
            rem[a]       = s2_n2_reg[a] - s2_qd_reg[a];
            q[a]         = s2_qa_reg[a] + CB'(rem[a] >= D2_C);
        end
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < 2; a++) begin
            if (cmd.load_anchor || cmd.load_end) begin
                p0_reg[a] <= pin[a];
            end
            if (cmd.load_ctrl && !cmd.ctrl_sel) begin
                p1_reg[a] <= pin[a];
            end
            if (cmd.load_ctrl && cmd.ctrl_sel) begin
                p2_reg[a] <= pin[a];
            end
            if (cmd.load_end) begin
                c1_reg[a] <= c1_next[a];
                c2_reg[a] <= c2_next[a];
                c3_reg[a] <= c3_next[a];
                f_reg[a]  <= f0_next[a];
            end else if (cmd.issue) begin
                f_reg[a]  <= f_reg[a] + d1_reg[a];
            end
            if (cmd.setup) begin
                d1_reg[a] <= d1_next[a];
                d2_reg[a] <= d2_next[a];
                d3_reg[a] <= d3_next[a];
            end else if (cmd.issue) begin
                d1_reg[a] <= d1_reg[a] + d2_reg[a];
                d2_reg[a] <= d2_reg[a] + d3_reg[a];
            end
            if (adv) begin
                s1_n2_reg[a]   <= n2_next[a];
                s1_prod_reg[a] <= prod_next[a];
                s2_n2_reg[a]   <= s1_n2_reg[a];
                s2_qa_reg[a]   <= qa_next[a];
                s2_qd_reg[a]   <= qd_next[a];
                if (s2_valid_reg) begin
                    prev_reg[a] <= q[a];
                    from_reg[a] <= prev_reg[a];
                    to_reg[a]   <= q[a];
                end
            end
        end
        if (adv) begin
            s1_emit_reg <= cmd.emit;
            s1_last_reg <= cmd.last;
            s2_emit_reg <= s1_emit_reg;
            s2_last_reg <= s1_last_reg;
            if (s2_valid_reg) begin
                last_reg <= s2_last_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            m_tvalid_reg <= s2_valid_reg && s2_emit_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign from_x   = from_reg[0];
    assign from_y   = from_reg[1];
    assign to_x     = to_reg[0];
    assign to_y     = to_reg[1];
    assign last     = last_reg;

endmodule

>>> sv/cubic_bezier_flattener_unit.sv
// Top level of the cubic Bezier flattener: stream ports, field packing, and the
// controller and datapath. Depends on cbf_pkg, cbf_ctrl and cbf_datapath.
//
// Usage: control points arrive one per transaction on the s_ channel; s_tuser set
// marks a point as the first anchor of a new curve. Every third point after an
// anchor closes a cubic segment, which is sampled at SAMPLE_STEPS + 1 evenly spaced
// parameter values with exact half-up rounding. Each sample after the first of a
// chain leaves on the m_ channel as one line from the previous sample; m_tlast marks
// the final line of a segment. The chain runs across segment joins.
// Sequencing: anchor and control points are accepted while the controller is idle.
// A point that closes a segment holds s_tready low while the forward differences
// are built and its samples are issued, one per cycle while the output is not
// stalled, into a three-stage reciprocal divide pipeline. On the first segment of
// a curve the first sample only seeds the chain. s_tready rises again once the
// final sample is issued, so further points can be taken while the last samples
// of a segment still pass through the divide pipeline.
// Reset (aresetn low, synchronous) forgets any curve and empties the pipeline.
// When a line waits in the output register and m_tready is low, the register holds
// it and the whole sample pipeline waits with it; no line is lost or repeated.
module cubic_bezier_flattener_unit import cbf_pkg::*; #(
    parameter int COORD_BITS   = 12,
    parameter int SAMPLE_STEPS = 60
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // point_x, point_y
    input  logic [((2 * COORD_BITS + 7) / 8) * 8-1:0] s_tdata,
    // new_curve
    input  logic                                     s_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // from_x, from_y, to_x, to_y
    output logic [((4 * COORD_BITS + 7) / 8) * 8-1:0] m_tdata,
    output logic                                     m_tlast
);

    localparam int OUT_W = ((4 * COORD_BITS + 7) / 8) * 8;

    cbf_cmd_t              cmd;
    cbf_status_t           status;
    logic [COORD_BITS-1:0] from_x, from_y, to_x, to_y;

    cbf_ctrl #(
        .SAMPLE_STEPS(SAMPLE_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .new_curve(s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    cbf_datapath #(
        .COORD_BITS  (COORD_BITS),
        .SAMPLE_STEPS(SAMPLE_STEPS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .point_x (s_tdata[COORD_BITS-1:0]),
        .point_y (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .m_tready(m_tready),
        .m_tvalid(m_tvalid),
        .from_x  (from_x),
        .from_y  (from_y),
        .to_x    (to_x),
        .to_y    (to_y),
        .last    (m_tlast)
    );

    assign m_tdata = OUT_W'({to_y, to_x, from_y, from_x});

endmodule
